/* hw/rtl/tqprs_pkg.sv */
package tqprs_pkg;

  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 3;
  localparam int ID_W       = 16;
  localparam int TIME_W     = 32;
  localparam int CNT_W      = 32;
  localparam int SUM_W      = 48;
  localparam int QCNT_W     = 5;
  localparam int LIMIT_W    = 5;
  localparam int ENTRY_W    = ID_W + TIME_W;
  localparam int IN_DATA_W  = ID_W + 2 * TIME_W;
  localparam int OUT_USED_W = ID_W + TIME_W + 2 * QCNT_W + 5 * CNT_W + 2 * SUM_W;
  localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  // Event counter slots.
  localparam int EV_LAND_REF = 0;
  localparam int EV_DEP_REF  = 1;
  localparam int EV_LANDED   = 2;
  localparam int EV_TOOKOFF  = 3;
  localparam int EV_IDLE     = 4;
  localparam int EV_NUM      = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_LAND   = 2'd0,
    CMD_DEPART = 2'd1,
    CMD_TICK   = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED = 3'd0,
    ST_REFUSED  = 3'd1,
    ST_LANDED   = 3'd2,
    ST_TOOKOFF  = 3'd3,
    ST_IDLE     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_READ = 2'd1,
    S_ADD  = 2'd2
  } state_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] value);
    logic [CNT_W-1:0] result;
    result = (value == '1) ? value : value + 1'b1;
    return result;
  endfunction

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] sum,
                                               input logic [TIME_W-1:0] addend);
    logic [SUM_W:0] total;
    total = {1'b0, sum} + (SUM_W + 1)'(addend);
    return total[SUM_W] ? '1 : total[SUM_W-1:0];
  endfunction

endpackage

/* hw/rtl/tqprs_ram.sv */
module tqprs_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/two_queue_priority_runway_scheduler.sv */
// Channel   Dir  Group                 Contents
// s_        in   tvalid/tready/tdata   tuser = cmd, tdata = plane_id, arrival_time, now_time
// m_        out  tvalid/tready/tdata   tuser = status, tdata = served item and statistics
// cfg_      in   wen/wdata             admission limit, written when cfg_wen is high
//
// A request, an unused command or a tick with both queues empty is answered from S_IDLE.
// A tick that serves a plane passes through S_IDLE, which issues the queue memory read,
// S_READ, which uses the registered read data for the wait subtraction, and S_ADD, which
// forms the saturating 48-bit wait sum. Reset clears all control state at once; queue
// memories need no clearing. A result that is not taken holds further items at s_tready.
module two_queue_priority_runway_scheduler #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // plane_id [15:0], arrival_time [47:16], now_time [79:48]
  input  logic [tqprs_pkg::IN_DATA_W-1:0]    s_tdata,
  // cmd [1:0]
  input  logic [tqprs_pkg::CMD_W-1:0]        s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // served_plane [15:0], served_wait [47:16], land_queue_count [52:48],
  // depart_queue_count [57:53], land_refused_total [89:58],
  // depart_refused_total [121:90], landings_total [153:122],
  // takeoffs_total [185:154], idle_total [217:186], land_wait_total [265:218],
  // depart_wait_total [313:266], zero fill [319:314]
  output logic [tqprs_pkg::OUT_DATA_W-1:0]   m_tdata,
  // status [2:0]
  output logic [tqprs_pkg::STATUS_W-1:0]     m_tuser,
  input  logic                               cfg_wen,
  input  logic [tqprs_pkg::LIMIT_W-1:0]      cfg_wdata
);

  import tqprs_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
  localparam logic [LW-1:0] DEPTH_L  = LW'(QUEUE_DEPTH);

  state_t state, state_next;

  logic [LIMIT_W-1:0] admit_limit;
  logic [AW-1:0]      land_head, land_tail, depart_head, depart_tail;
  logic [CW-1:0]      land_count, depart_count;
  logic [CNT_W-1:0]   evt_count [EV_NUM];
  logic [SUM_W-1:0]   land_wait_sum, depart_wait_sum;

  status_t            out_status;
  logic [ID_W-1:0]    out_plane;
  logic [TIME_W-1:0]  out_wait;
  logic [TIME_W-1:0]  tick_now;
  logic               pop_land;
  logic [ID_W-1:0]    pop_plane;
  logic [TIME_W-1:0]  pop_wait;

  logic [ID_W-1:0]    in_plane;
  logic [TIME_W-1:0]  in_arrival, in_now;
  cmd_t               in_cmd;
  logic               accept;
  logic [LW-1:0]      limit_ext, eff_limit;
  logic               land_full, depart_full;
  logic               land_push, depart_push, land_rd, depart_rd;
  logic               req_load, pop_done;
  status_t            req_status;
  logic [EV_NUM-1:0]  ev_bump;
  logic [ENTRY_W-1:0] land_rdata, depart_rdata, pop_entry;

  assign in_plane   = s_tdata[ID_W-1:0];
  assign in_arrival = s_tdata[ID_W+TIME_W-1:ID_W];
  assign in_now     = s_tdata[ID_W+2*TIME_W-1:ID_W+TIME_W];
  assign in_cmd     = cmd_t'(s_tuser);

  assign s_tready = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  assign limit_ext   = LW'(admit_limit);
  assign eff_limit   = (limit_ext > DEPTH_L) ? DEPTH_L : limit_ext;
  assign land_full   = LW'(land_count) >= eff_limit;
  assign depart_full = LW'(depart_count) >= eff_limit;

  // A push and a pop never fall in the same cycle, and a pop reads an entry
  // written in an earlier cycle, so the memories need no forwarding.
  tqprs_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_land_ram (
    .clk   (clk),
    .we    (land_push),
    .waddr (land_tail),
    .wdata ({in_plane, in_arrival}),
    .re    (land_rd),
    .raddr (land_head),
    .rdata (land_rdata)
  );

  tqprs_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_depart_ram (
    .clk   (clk),
    .we    (depart_push),
    .waddr (depart_tail),
    .wdata ({in_plane, in_arrival}),
    .re    (depart_rd),
    .raddr (depart_head),
    .rdata (depart_rdata)
  );

  assign pop_entry = pop_land ? land_rdata : depart_rdata;

  always_comb begin
    state_next  = state;
    land_push   = 1'b0;
    depart_push = 1'b0;
    land_rd     = 1'b0;
    depart_rd   = 1'b0;
    req_load    = 1'b0;
    req_status  = ST_REFUSED;
    pop_done    = 1'b0;
    ev_bump     = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_LAND: begin
              req_load = 1'b1;
              if (!land_full) begin
                land_push  = 1'b1;
                req_status = ST_ACCEPTED;
              end else begin
                ev_bump[EV_LAND_REF] = 1'b1;
              end
            end
            CMD_DEPART: begin
              req_load = 1'b1;
              if (!depart_full) begin
                depart_push = 1'b1;
                req_status  = ST_ACCEPTED;
              end else begin
                ev_bump[EV_DEP_REF] = 1'b1;
              end
            end
            CMD_TICK: begin
              if (land_count != '0) begin
                land_rd    = 1'b1;
                state_next = S_READ;
              end else if (depart_count != '0) begin
                depart_rd  = 1'b1;
                state_next = S_READ;
              end else begin
                req_load          = 1'b1;
                req_status        = ST_IDLE;
                ev_bump[EV_IDLE]  = 1'b1;
              end
            end
            default: begin
              req_load = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        state_next = S_ADD;
      end
      S_ADD: begin
        pop_done   = 1'b1;
        state_next = S_IDLE;
        if (pop_land) begin
          ev_bump[EV_LANDED] = 1'b1;
        end else begin
          ev_bump[EV_TOOKOFF] = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      admit_limit     <= LIMIT_RESET;
      land_head       <= '0;
      land_tail       <= '0;
      land_count      <= '0;
      depart_head     <= '0;
      depart_tail     <= '0;
      depart_count    <= '0;
      land_wait_sum   <= '0;
      depart_wait_sum <= '0;
      m_tvalid        <= 1'b0;
      for (int i = 0; i < EV_NUM; i++) begin
        evt_count[i] <= '0;
      end
    end else begin
      if (cfg_wen) begin
        admit_limit <= cfg_wdata;
      end
      if (land_push) begin
        land_tail  <= (land_tail == LAST_IDX) ? '0 : land_tail + 1'b1;
        land_count <= land_count + 1'b1;
      end
      if (depart_push) begin
        depart_tail  <= (depart_tail == LAST_IDX) ? '0 : depart_tail + 1'b1;
        depart_count <= depart_count + 1'b1;
      end
      if (pop_done) begin
        if (pop_land) begin
          land_head     <= (land_head == LAST_IDX) ? '0 : land_head + 1'b1;
          land_count    <= land_count - 1'b1;
          land_wait_sum <= sat_add(land_wait_sum, pop_wait);
        end else begin
          depart_head     <= (depart_head == LAST_IDX) ? '0 : depart_head + 1'b1;
          depart_count    <= depart_count - 1'b1;
          depart_wait_sum <= sat_add(depart_wait_sum, pop_wait);
        end
      end
      for (int i = 0; i < EV_NUM; i++) begin
        if (ev_bump[i]) begin
          evt_count[i] <= sat_inc(evt_count[i]);
        end
      end
      if (req_load || pop_done) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tick_now <= in_now;
      pop_land <= (land_count != '0);
    end
    if (state == S_READ) begin
      pop_plane <= pop_entry[ENTRY_W-1:TIME_W];
      pop_wait  <= tick_now - pop_entry[TIME_W-1:0];
    end
    if (req_load) begin
      out_status <= req_status;
      out_plane  <= '0;
      out_wait   <= '0;
    end else if (pop_done) begin
      out_status <= pop_land ? ST_LANDED : ST_TOOKOFF;
      out_plane  <= pop_plane;
      out_wait   <= pop_wait;
    end
  end

  // The statistics are shown live: they only move when a result is loaded, and
  // no item is taken while a result waits, so they match the pending result.
  assign m_tuser = out_status;
  assign m_tdata = {{OUT_PAD_W{1'b0}}, depart_wait_sum, land_wait_sum,
                    evt_count[EV_IDLE], evt_count[EV_TOOKOFF], evt_count[EV_LANDED],
                    evt_count[EV_DEP_REF], evt_count[EV_LAND_REF],
                    QCNT_W'(depart_count), QCNT_W'(land_count), out_wait, out_plane};

endmodule

/* hw/rtl/tqprs_chk.sv */
module tqprs_chk (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [tqprs_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [tqprs_pkg::STATUS_W-1:0]   m_tuser
);

  import tqprs_pkg::*;

  // A result that is held must not change.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // No new item may enter while a result still waits.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !(s_tvalid && s_tready))
    else $error("item taken while result stalled");

  // Results that serve no plane carry zero plane and wait fields.
  a_unserved_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_ACCEPTED || m_tuser == ST_REFUSED || m_tuser == ST_IDLE)
    |-> m_tdata[47:0] == '0)
    else $error("served fields not zero");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser <= ST_IDLE)
    else $error("status out of range");

  // The landing total only ever counts up.
  a_land_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> m_tdata[153:122] >= $past(m_tdata[153:122]))
    else $error("landings total went down");

endmodule

bind two_queue_priority_runway_scheduler tqprs_chk u_tqprs_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

/* verif/tb_two_queue_priority_runway_scheduler.sv */
`timescale 1ns / 100ps

module tb_two_queue_priority_runway_scheduler;
  import tqprs_pkg::*;

  localparam int DEPTH           = 16;
  localparam int HOLD_CYCLES     = 80;
  localparam int SETTLE_CYCLES   = 8;
  localparam int DRAIN_LIMIT     = 20000;
  localparam int ITEMS_PER_PHASE = 140;
  localparam int PHASES          = 7;
  localparam int FULL_ROUNDS     = 1;
  localparam int DIRECTED_ROWS   = 25;

  // The block answers the spare command code with a refusal.
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  typedef enum logic {
    ROW_ITEM,
    ROW_LIMIT
  } row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [LIMIT_W-1:0] limit;
    logic [CMD_W-1:0]   cmd;
    logic [ID_W-1:0]    id;
    logic [TIME_W-1:0]  arrival;
    logic [TIME_W-1:0]  now;
    logic               typed;
    status_t            status;
    logic [ID_W-1:0]    plane;
    logic [TIME_W-1:0]  served_wait;
  } script_row_t;

  typedef struct packed {
    logic              typed;
    status_t           status;
    logic [ID_W-1:0]   plane;
    logic [TIME_W-1:0] served_wait;
  } quoted_outcome_t;

  typedef struct packed {
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] arrival;
    logic [ID_W-1:0]   plane_id;
  } request_word_t;

  typedef struct packed {
    logic [OUT_PAD_W-1:0] fill;
    logic [SUM_W-1:0]     depart_wait_total;
    logic [SUM_W-1:0]     land_wait_total;
    logic [CNT_W-1:0]     idle_total;
    logic [CNT_W-1:0]     takeoffs_total;
    logic [CNT_W-1:0]     landings_total;
    logic [CNT_W-1:0]     depart_refused_total;
    logic [CNT_W-1:0]     land_refused_total;
    logic [QCNT_W-1:0]    depart_queue_count;
    logic [QCNT_W-1:0]    land_queue_count;
    logic [TIME_W-1:0]    served_wait;
    logic [ID_W-1:0]      served_plane;
  } report_word_t;

  typedef struct packed {
    status_t      status;
    report_word_t word;
  } runway_report_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] arrival;
  } plane_entry_t;

  localparam quoted_outcome_t NO_QUOTE = '0;

  localparam logic [LIMIT_W-1:0] PHASE_LIMIT [PHASES] = '{5'd16, 5'd3, 5'd31, 5'd0, 5'd1,
                                                          5'd20, 5'd8};
  localparam int PHASE_TICK_PCT [PHASES] = '{35, 30, 25, 40, 45, 30, 50};

  localparam script_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{ROW_LIMIT, 5'd16, CMD_TICK, 16'h0, 32'h0, 32'h0, 1'b0, ST_ACCEPTED, 16'h0, 32'h0},
    '{ROW_ITEM, 5'd0, CMD_TICK, 16'hFFFF, 32'hFFFFFFFF, 32'h5, 1'b1, ST_IDLE, 16'h0, 32'h0},
    '{ROW_ITEM, 5'd0, CMD_SPARE, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, ST_REFUSED,
      16'h0, 32'h0},
    '{ROW_ITEM, 5'd0, CMD_LAND, 16'hFFFF, 32'hFFFFFFFF, 32'h0, 1'b1, ST_ACCEPTED, 16'h0, 32'h0},
    '{ROW_ITEM, 5'd0, CMD_LAND, 16'h0, 32'h0, 32'hFFFFFFFF, 1'b1, ST_ACCEPTED, 16'h0, 32'h0},
    '{ROW_ITEM, 5'd0, CMD_DEPART, 16'h1234, 32'd100, 32'h0, 1'b1, ST_ACCEPTED, 16'h0, 32'h0},
    '{ROW_ITEM, 5'd0, CMD_DEPART, 16'hFFFF, 32'h0, 32'h0, 1'b1, ST_ACCEPTED, 16'h0, 32'h0},
    // Waits wrap modulo 2^32 when now is behind the arrival time.
    '{ROW_ITEM, 5'd0, CMD_TICK, 16'h0, 32'h0, 32'h0, 1'b1, ST_LANDED, 16'hFFFF, 32'h1},
    '{ROW_ITEM, 5'd0, CMD_TICK, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, ST_LANDED,
      16'h0, 32'hFFFFFFFF},
    '{ROW_ITEM, 5'd0, CMD_TICK, 16'h0, 32'h0, 32'd50, 1'b1, ST_TOOKOFF, 16'h1234, 32'hFFFFFFCE},
    '{ROW_ITEM, 5'd0, CMD_TICK, 16'h0, 32'h0, 32'hFFFFFFFF, 1'b1, ST_TOOKOFF, 16'hFFFF,
      32'hFFFFFFFF},
    '{ROW_ITEM, 5'd0, CMD_TICK, 16'h0, 32'h0, 32'h0, 1'b1, ST_IDLE, 16'h0, 32'h0},
    '{ROW_LIMIT, 5'd0, CMD_TICK, 16'h0, 32'h0, 32'h0, 1'b0, ST_ACCEPTED, 16'h0, 32'h0},
    '{ROW_ITEM, 5'd0, CMD_LAND, 16'h0042, 32'h10, 32'h0, 1'b1, ST_REFUSED, 16'h0, 32'h0},
    '{ROW_ITEM, 5'd0, CMD_DEPART, 16'h0043, 32'h11, 32'h0, 1'b1, ST_REFUSED, 16'h0, 32'h0},
    '{ROW_ITEM, 5'd0, CMD_TICK, 16'h0, 32'h0, 32'h20, 1'b1, ST_IDLE, 16'h0, 32'h0},
    '{ROW_LIMIT, 5'd1, CMD_TICK, 16'h0, 32'h0, 32'h0, 1'b0, ST_ACCEPTED, 16'h0, 32'h0},
    '{ROW_ITEM, 5'd0, CMD_LAND, 16'h00AA, 32'd7, 32'h0, 1'b1, ST_ACCEPTED, 16'h0, 32'h0},
    '{ROW_ITEM, 5'd0, CMD_LAND, 16'h00BB, 32'd8, 32'h0, 1'b1, ST_REFUSED, 16'h0, 32'h0},
    '{ROW_ITEM, 5'd0, CMD_DEPART, 16'h00CC, 32'd9, 32'h0, 1'b1, ST_ACCEPTED, 16'h0, 32'h0},
    '{ROW_ITEM, 5'd0, CMD_DEPART, 16'h00DD, 32'd9, 32'h0, 1'b1, ST_REFUSED, 16'h0, 32'h0},
    '{ROW_ITEM, 5'd0, CMD_TICK, 16'h0, 32'h0, 32'd7, 1'b1, ST_LANDED, 16'h00AA, 32'h0},
    '{ROW_ITEM, 5'd0, CMD_TICK, 16'h0, 32'h0, 32'd10, 1'b1, ST_TOOKOFF, 16'h00CC, 32'h1},
    '{ROW_LIMIT, 5'd31, CMD_TICK, 16'h0, 32'h0, 32'h0, 1'b0, ST_ACCEPTED, 16'h0, 32'h0},
    '{ROW_ITEM, 5'd0, CMD_SPARE, 16'h0, 32'h0, 32'h0, 1'b1, ST_REFUSED, 16'h0, 32'h0}
  };

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata;
  logic [CMD_W-1:0]       s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_DATA_W-1:0]  m_tdata;
  logic [STATUS_W-1:0]    m_tuser;
  logic                   cfg_wen;
  logic [LIMIT_W-1:0]     cfg_wdata;

  two_queue_priority_runway_scheduler #(
    .QUEUE_DEPTH(DEPTH)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  // Scheduler state as the testbench expects it to be.
  logic [LIMIT_W-1:0] model_limit;
  plane_entry_t       landing_line [$];
  plane_entry_t       departure_line [$];
  logic [CNT_W-1:0]   land_refusals;
  logic [CNT_W-1:0]   depart_refusals;
  logic [CNT_W-1:0]   landings;
  logic [CNT_W-1:0]   takeoffs;
  logic [CNT_W-1:0]   idle_ticks;
  logic [SUM_W-1:0]   land_wait_sum;
  logic [SUM_W-1:0]   depart_wait_sum;

  runway_report_t     due_reports [$];
  quoted_outcome_t    quoted_outcomes [$];
  int                 failures = 0;
  bit                 hold_request = 1'b0;
  bit                 steady_sink = 1'b0;
  logic [TIME_W-1:0]  runway_clock;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [CNT_W-1:0] bumped(input logic [CNT_W-1:0] count);
    return (count == '1) ? count : count + 1'b1;
  endfunction

  function automatic logic [SUM_W-1:0] wait_sum_plus(input logic [SUM_W-1:0] sum,
                                                     input logic [TIME_W-1:0] wait_cycles);
    logic [SUM_W:0] total;
    total = {1'b0, sum} + {{(SUM_W + 1 - TIME_W){1'b0}}, wait_cycles};
    return total[SUM_W] ? '1 : total[SUM_W-1:0];
  endfunction

  function automatic runway_report_t runway_outcome(input logic [CMD_W-1:0] cmd,
                                                    input request_word_t req);
    runway_report_t r;
    plane_entry_t   e;
    int             cap;
    cap = (int'(model_limit) > DEPTH) ? DEPTH : int'(model_limit);
    r = '0;
    r.status = ST_REFUSED;
    case (cmd)
      CMD_LAND: begin
        if (landing_line.size() < cap) begin
          landing_line.push_back('{req.plane_id, req.arrival});
          r.status = ST_ACCEPTED;
        end else begin
          land_refusals = bumped(land_refusals);
        end
      end
      CMD_DEPART: begin
        if (departure_line.size() < cap) begin
          departure_line.push_back('{req.plane_id, req.arrival});
          r.status = ST_ACCEPTED;
        end else begin
          depart_refusals = bumped(depart_refusals);
        end
      end
      CMD_TICK: begin
        // Landings always go ahead of takeoffs.
        if (landing_line.size() > 0) begin
          e = landing_line.pop_front();
          r.status = ST_LANDED;
          r.word.served_plane = e.id;
          r.word.served_wait = req.now - e.arrival;
          landings = bumped(landings);
          land_wait_sum = wait_sum_plus(land_wait_sum, r.word.served_wait);
        end else if (departure_line.size() > 0) begin
          e = departure_line.pop_front();
          r.status = ST_TOOKOFF;
          r.word.served_plane = e.id;
          r.word.served_wait = req.now - e.arrival;
          takeoffs = bumped(takeoffs);
          depart_wait_sum = wait_sum_plus(depart_wait_sum, r.word.served_wait);
        end else begin
          r.status = ST_IDLE;
          idle_ticks = bumped(idle_ticks);
        end
      end
      default: begin
      end
    endcase
    r.word.land_queue_count     = QCNT_W'(landing_line.size());
    r.word.depart_queue_count   = QCNT_W'(departure_line.size());
    r.word.land_refused_total   = land_refusals;
    r.word.depart_refused_total = depart_refusals;
    r.word.landings_total       = landings;
    r.word.takeoffs_total       = takeoffs;
    r.word.idle_total           = idle_ticks;
    r.word.land_wait_total      = land_wait_sum;
    r.word.depart_wait_total    = depart_wait_sum;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [SUM_W-1:0] want,
                                      input logic [SUM_W-1:0] got);
    if (want !== got) begin
      failures++;
      $error("%s: expected %0h, got %0h", name, want, got);
    end
  endfunction

  always @(posedge clk) begin : scoreboard
    runway_report_t  want;
    quoted_outcome_t quote;
    report_word_t    got;
    if (rst) begin
      model_limit = LIMIT_RESET;
      landing_line.delete();
      departure_line.delete();
      land_refusals = '0;
      depart_refusals = '0;
      landings = '0;
      takeoffs = '0;
      idle_ticks = '0;
      land_wait_sum = '0;
      depart_wait_sum = '0;
      due_reports.delete();
    end else begin
      if (cfg_wen)
        model_limit = cfg_wdata;
      // The accepted item is predicted first so a same-edge result still finds it.
      if (s_tvalid && s_tready) begin
        want = runway_outcome(s_tuser, request_word_t'(s_tdata));
        quote = (quoted_outcomes.size() > 0) ? quoted_outcomes.pop_front() : NO_QUOTE;
        if (quote.typed) begin
          want.status = quote.status;
          want.word.served_plane = quote.plane;
          want.word.served_wait = quote.served_wait;
        end
        due_reports.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        if (due_reports.size() == 0) begin
          failures++;
          $error("result with no item outstanding: status %0d", m_tuser);
        end else begin
          want = due_reports.pop_front();
          got = report_word_t'(m_tdata);
          check_field("status", SUM_W'(want.status), SUM_W'(m_tuser));
          check_field("served_plane", SUM_W'(want.word.served_plane), SUM_W'(got.served_plane));
          check_field("served_wait", SUM_W'(want.word.served_wait), SUM_W'(got.served_wait));
          check_field("land_queue_count", SUM_W'(want.word.land_queue_count),
                      SUM_W'(got.land_queue_count));
          check_field("depart_queue_count", SUM_W'(want.word.depart_queue_count),
                      SUM_W'(got.depart_queue_count));
          check_field("land_refused_total", SUM_W'(want.word.land_refused_total),
                      SUM_W'(got.land_refused_total));
          check_field("depart_refused_total", SUM_W'(want.word.depart_refused_total),
                      SUM_W'(got.depart_refused_total));
          check_field("landings_total", SUM_W'(want.word.landings_total),
                      SUM_W'(got.landings_total));
          check_field("takeoffs_total", SUM_W'(want.word.takeoffs_total),
                      SUM_W'(got.takeoffs_total));
          check_field("idle_total", SUM_W'(want.word.idle_total), SUM_W'(got.idle_total));
          check_field("land_wait_total", want.word.land_wait_total, got.land_wait_total);
          check_field("depart_wait_total", want.word.depart_wait_total, got.depart_wait_total);
        end
      end
    end
  end

  function automatic int pause_length();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 80)
      return int'($urandom_range(1, 2));
    if (r < 95)
      return int'($urandom_range(3, 8));
    return int'($urandom_range(15, 40));
  endfunction

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
        m_tready <= 1'b1;
      end else if (!steady_sink && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat (pause_length()) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic offer(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                       input logic [TIME_W-1:0] arrival, input logic [TIME_W-1:0] now,
                       input quoted_outcome_t quote);
    quoted_outcomes.push_back(quote);
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {now, arrival, id};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic sender_gap(input bit steady);
    if (!steady && $urandom_range(0, 2) == 0) begin
      s_tvalid <= 1'b0;
      s_tuser <= CMD_W'($urandom);
      s_tdata <= {$urandom, $urandom, ID_W'($urandom)};
      repeat (pause_length()) @(posedge clk);
    end
  endtask

  task automatic pause_until_drained();
    int n;
    s_tvalid <= 1'b0;
    n = 0;
    // A clock edge passes first, so the last accepted item is already predicted.
    @(posedge clk);
    while (due_reports.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    if (due_reports.size() != 0) begin
      failures++;
      $error("%0d results never arrived", due_reports.size());
      due_reports.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_limit(input logic [LIMIT_W-1:0] value);
    pause_until_drained();
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic send_random(input int tick_pct);
    logic [CMD_W-1:0]  cmd;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] now;
    int                r;
    r = int'($urandom_range(0, 99));
    if (r < 3)
      cmd = CMD_SPARE;
    else if (r < 3 + tick_pct)
      cmd = CMD_TICK;
    else if ($urandom_range(0, 1) == 0)
      cmd = CMD_LAND;
    else
      cmd = CMD_DEPART;
    // Mostly plausible waits against a running clock, sometimes arbitrary times.
    runway_clock = runway_clock + TIME_W'($urandom_range(0, 20));
    arrival = ($urandom_range(0, 3) != 0) ? runway_clock - TIME_W'($urandom_range(0, 500))
                                          : $urandom;
    now = ($urandom_range(0, 3) != 0) ? runway_clock : $urandom;
    offer(cmd, ID_W'($urandom), arrival, now, NO_QUOTE);
  endtask

  initial begin : stimulus
    script_row_t row;
    bit          steady;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= '0;
    cfg_wen <= 1'b0;
    cfg_wdata <= '0;
    runway_clock = $urandom;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row = DIRECTED[i];
      if (row.kind == ROW_LIMIT) begin
        set_limit(row.limit);
      end else begin
        offer(row.cmd, row.id, row.arrival, row.now,
              '{row.typed, row.status, row.plane, row.served_wait});
        sender_gap(1'b0);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      set_limit(PHASE_LIMIT[phase]);
      // The hold-off phase offers items back to back so the block backs up.
      steady = (phase == 1) || ($urandom_range(0, 2) == 0);
      steady_sink = steady;
      if (phase == 1)
        hold_request = 1'b1;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (phase == 3 && k == ITEMS_PER_PHASE / 2)
          pause_until_drained();
        send_random(PHASE_TICK_PCT[phase]);
        sender_gap(steady);
      end
    end

    // Push each queue past its depth with maximal waits; the request beyond
    // the depth finds the queue full and is refused.
    set_limit(5'd31);
    steady_sink = 1'b1;
    for (int round = 0; round < 2 * FULL_ROUNDS; round++) begin
      for (int k = 0; k <= DEPTH; k++)
        offer((round < FULL_ROUNDS) ? CMD_LAND : CMD_DEPART, ID_W'(round + k), '0, '0,
              NO_QUOTE);
      for (int k = 0; k < DEPTH; k++)
        offer(CMD_TICK, '0, '0, '1, NO_QUOTE);
    end

    pause_until_drained();
    if (failures == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/tqprs_pkg.sv
hw/rtl/tqprs_ram.sv
hw/rtl/two_queue_priority_runway_scheduler.sv
hw/rtl/tqprs_chk.sv
verif/tb_two_queue_priority_runway_scheduler.sv
